// ===== hw/rtl/c8ex_pkg.sv =====
// c8ex_pkg: shared constants, codes, font table and control types of the
// CHIP-8 instruction executor. No dependencies.
package c8ex_pkg;

   localparam int MEM_BYTES     = 4096;
   localparam int STACK_DEPTH   = 16;
   localparam int SCREEN_WIDTH  = 64;
   localparam int SCREEN_HEIGHT = 32;
   localparam int FONT_BASE     = 0;
   localparam int PROGRAM_START = 512;
   localparam int FONT_BYTES    = 80;

   localparam int MEM_AW = $clog2(MEM_BYTES);
   localparam int SP_W   = $clog2(STACK_DEPTH);
   localparam int ROW_W  = $clog2(SCREEN_HEIGHT);
   localparam int COL_W  = $clog2(SCREEN_WIDTH);

   typedef enum logic [1:0] {
      CMD_EXEC      = 2'd0,
      CMD_WRITE_MEM = 2'd1,
      CMD_READ_MEM  = 2'd2,
      CMD_READ_DISP = 2'd3
   } cmd_type;

   localparam logic [3:0] OPG_SYS   = 4'h0;
   localparam logic [3:0] OPG_JP    = 4'h1;
   localparam logic [3:0] OPG_CALL  = 4'h2;
   localparam logic [3:0] OPG_SE_I  = 4'h3;
   localparam logic [3:0] OPG_SNE_I = 4'h4;
   localparam logic [3:0] OPG_SE_R  = 4'h5;
   localparam logic [3:0] OPG_LD_I  = 4'h6;
   localparam logic [3:0] OPG_ADD_I = 4'h7;
   localparam logic [3:0] OPG_ALU   = 4'h8;
   localparam logic [3:0] OPG_SNE_R = 4'h9;
   localparam logic [3:0] OPG_SET_I = 4'hA;
   localparam logic [3:0] OPG_JP_V0 = 4'hB;
   localparam logic [3:0] OPG_RND   = 4'hC;
   localparam logic [3:0] OPG_DRAW  = 4'hD;
   localparam logic [3:0] OPG_KEY   = 4'hE;
   localparam logic [3:0] OPG_MISC  = 4'hF;

   localparam logic [15:0] OP_CLS = 16'h00E0;
   localparam logic [15:0] OP_RET = 16'h00EE;

   localparam logic [3:0] ALU_MOV  = 4'h0;
   localparam logic [3:0] ALU_OR   = 4'h1;
   localparam logic [3:0] ALU_AND  = 4'h2;
   localparam logic [3:0] ALU_XOR  = 4'h3;
   localparam logic [3:0] ALU_ADD  = 4'h4;
   localparam logic [3:0] ALU_SUB  = 4'h5;
   localparam logic [3:0] ALU_SHR  = 4'h6;
   localparam logic [3:0] ALU_SUBN = 4'h7;
   localparam logic [3:0] ALU_SHL  = 4'hE;

   localparam logic [7:0] KEY_DOWN = 8'h9E;
   localparam logic [7:0] KEY_UP   = 8'hA1;

   localparam logic [7:0] F_GET_DT   = 8'h07;
   localparam logic [7:0] F_WAIT_KEY = 8'h0A;
   localparam logic [7:0] F_SET_DT   = 8'h15;
   localparam logic [7:0] F_SET_ST   = 8'h18;
   localparam logic [7:0] F_ADD_I    = 8'h1E;
   localparam logic [7:0] F_FONT     = 8'h29;
   localparam logic [7:0] F_BCD      = 8'h33;
   localparam logic [7:0] F_STORE    = 8'h55;
   localparam logic [7:0] F_LOAD     = 8'h65;

   localparam logic [11:0] REG_SEL_BASE = 12'd32;
   localparam logic [11:0] REG_SEL_END  = 12'd48;

   localparam logic [7:0] FONT_ROM [FONT_BYTES] = '{
      8'hF0, 8'h90, 8'h90, 8'h90, 8'hF0, 8'h20, 8'h60, 8'h20, 8'h20, 8'h70,
      8'hF0, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h10, 8'hF0, 8'h10, 8'hF0,
      8'h90, 8'h90, 8'hF0, 8'h10, 8'h10, 8'hF0, 8'h80, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h80, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h10, 8'h20, 8'h40, 8'h40,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'hF0, 8'hF0, 8'h90, 8'hF0, 8'h10, 8'hF0,
      8'hF0, 8'h90, 8'hF0, 8'h90, 8'h90, 8'hE0, 8'h90, 8'hE0, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'h80, 8'h80, 8'hF0, 8'hE0, 8'h90, 8'h90, 8'h90, 8'hE0,
      8'hF0, 8'h80, 8'hF0, 8'h80, 8'hF0, 8'hF0, 8'h80, 8'hF0, 8'h80, 8'h80
   };

   function automatic logic [7:0] font_byte(input logic [MEM_AW-1:0] a);
      logic [MEM_AW-1:0] off;
      off = a - MEM_AW'(FONT_BASE);
      if (a >= MEM_AW'(FONT_BASE) && off < MEM_AW'(FONT_BYTES)) begin
         return FONT_ROM[off[6:0]];
      end
      return 8'h00;
   endfunction

   typedef enum logic [3:0] {
      ST_NONE,
      ST_CLEAR,
      ST_RDX,
      ST_RDY,
      ST_EXEC,
      ST_CAPTURE,
      ST_DRAW_RD,
      ST_DRAW_WR,
      ST_STORE,
      ST_LOAD_RD,
      ST_LOAD_WR
   } step_type;

   typedef enum logic [2:0] {
      K_SIMPLE,
      K_READ,
      K_DRAW,
      K_STORE,
      K_LOAD
   } kind_type;

   typedef struct packed {
      step_type step;
   } dp_cmd_type;

   typedef struct packed {
      kind_type kind;
      logic     clear_last;
      logic     draw_done;
      logic     move_last;
   } dp_stat_type;

endpackage

// ===== hw/rtl/c8ex_ifs.sv =====
// c8ex_ifs: request and response channel interfaces (valid/ready plus item).
// No dependencies.
interface c8ex_req_if;
   logic        valid;
   logic        ready;
   logic [1:0]  cmd;
   logic [15:0] opcode;
   logic [11:0] address;
   logic [7:0]  write_byte;
   logic [7:0]  random_byte;
   modport source (output valid, cmd, opcode, address, write_byte, random_byte,
                   input ready);
   modport sink (input valid, cmd, opcode, address, write_byte, random_byte,
                 output ready);
endinterface

interface c8ex_rsp_if;
   logic        valid;
   logic        ready;
   logic [11:0] prog_counter;
   logic [15:0] index_reg;
   logic [7:0]  flag_reg;
   logic [63:0] read_data;
   logic [7:0]  delay_value;
   logic [7:0]  sound_value;
   logic        bad_opcode;
   modport source (output valid, prog_counter, index_reg, flag_reg, read_data,
                   delay_value, sound_value, bad_opcode, input ready);
   modport sink (input valid, prog_counter, index_reg, flag_reg, read_data,
                 delay_value, sound_value, bad_opcode, output ready);
endinterface

// ===== hw/rtl/c8ex_dpath.sv =====
// c8ex_dpath: machine state (registers, stack, timers, memory, framebuffer)
// and the per-step datapath. Depends on c8ex_pkg.
module c8ex_dpath import c8ex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_fire,
   input  cmd_type     req_cmd,
   input  logic [15:0] req_opcode,
   input  logic [11:0] req_address,
   input  logic [7:0]  req_write_byte,
   input  logic [7:0]  req_random_byte,
   input  dp_cmd_type  dp_cmd,
   output dp_stat_type dp_stat,
   output logic [11:0] prog_counter,
   output logic [15:0] index_reg,
   output logic [7:0]  flag_reg,
   output logic [63:0] read_data,
   output logic [7:0]  delay_value,
   output logic [7:0]  sound_value,
   output logic        bad_opcode
);

   cmd_type     cmd_ff;
   logic [15:0] op_ff;
   logic [11:0] addr_ff;
   logic [7:0]  wbyte_ff, rnd_ff;

   logic [7:0]  regs_ff [16];
   logic [15:0] i_ff, i_in;
   logic [11:0] pc_ff, pc_in;
   logic [SP_W-1:0] sp_ff, sp_in;
   logic [11:0] stack_mem [STACK_DEPTH];
   logic [7:0]  dt_ff, dt_in, st_ff, st_in;
   logic [7:0]  vx_ff, vy_ff;
   logic [3:0]  cnt_ff;
   logic [MEM_AW-1:0] sweep_ff;
   logic        hit_ff;
   logic [63:0] data_ff;
   logic        bad_ff, bad_in;
   logic [ROW_W-1:0] row_ff;

   logic [7:0]  mem [MEM_BYTES];
   logic [7:0]  mem_rd_ff;
   logic        mem_we;
   logic [MEM_AW-1:0] mem_wa, mem_ra;
   logic [7:0]  mem_wd;

   logic [63:0] fb_mem [SCREEN_HEIGHT];
   logic [SCREEN_HEIGHT-1:0] fb_vld_ff;
   logic [63:0] fb_rd_ff;
   logic        fb_rv_ff;
   logic [ROW_W-1:0] fb_ra, draw_row;
   logic        fb_clear;
   logic [63:0] fb_cur, sprite_mask;
   logic [127:0] sprite_dbl;

   logic [3:0]  x, y, n, rd_sel;
   logic [7:0]  nn, rd_data;
   logic [11:0] nnn, pc_adv;
   logic [3:0]  grp;
   logic [8:0]  sum9;
   logic        rf_we, vf_we, stack_we;
   logic [3:0]  rf_wa;
   logic [7:0]  rf_wd, vf_wd;
   logic [MEM_AW-1:0] i_off;
   step_type    step;

   assign step = dp_cmd.step;
   assign x    = op_ff[11:8];
   assign y    = op_ff[7:4];
   assign n    = op_ff[3:0];
   assign nn   = op_ff[7:0];
   assign nnn  = op_ff[11:0];
   assign grp  = op_ff[15:12];
   assign pc_adv = pc_ff + 12'd2;
   assign sum9   = {1'b0, vx_ff} + {1'b0, vy_ff};
   assign i_off  = i_ff[MEM_AW-1:0] + MEM_AW'(cnt_ff);
   assign draw_row = vy_ff[ROW_W-1:0] + ROW_W'(cnt_ff);

   always_comb begin
      case (step)
         ST_RDX:   rd_sel = (cmd_ff == CMD_READ_DISP) ? addr_ff[3:0] : x;
         ST_RDY:   rd_sel = y;
         ST_STORE: rd_sel = cnt_ff;
         default:  rd_sel = x;
      endcase
   end
   assign rd_data = regs_ff[rd_sel];

   always_comb begin
      if (cmd_ff == CMD_READ_MEM || cmd_ff == CMD_READ_DISP) begin
         dp_stat.kind = K_READ;
      end else if (cmd_ff == CMD_WRITE_MEM) begin
         dp_stat.kind = K_SIMPLE;
      end else if (grp == OPG_DRAW) begin
         dp_stat.kind = K_DRAW;
      end else if (grp == OPG_MISC && nn == F_STORE) begin
         dp_stat.kind = K_STORE;
      end else if (grp == OPG_MISC && nn == F_LOAD) begin
         dp_stat.kind = K_LOAD;
      end else begin
         dp_stat.kind = K_SIMPLE;
      end
      dp_stat.clear_last = &sweep_ff;
      dp_stat.draw_done  = (cnt_ff == n);
      dp_stat.move_last  = (cnt_ff == x);
   end

   always_comb begin
      pc_in = pc_ff;
      i_in = i_ff;
      sp_in = sp_ff;
      dt_in = dt_ff;
      st_in = st_ff;
      bad_in = bad_ff;
      rf_we = 1'b0;
      rf_wa = x;
      rf_wd = 8'h00;
      vf_we = 1'b0;
      vf_wd = 8'h00;
      stack_we = 1'b0;
      fb_clear = 1'b0;
      case (step)
         ST_EXEC: begin
            bad_in = 1'b0;
            if (cmd_ff == CMD_EXEC) begin
               pc_in = pc_adv;
               case (grp)
                  OPG_SYS: begin
                     if (op_ff == OP_CLS) begin
                        fb_clear = 1'b1;
                     end else if (op_ff == OP_RET) begin
                        sp_in = (sp_ff == '0) ? SP_W'(STACK_DEPTH - 1) : sp_ff - 1'b1;
                        pc_in = stack_mem[sp_in];
                     end else begin
                        bad_in = 1'b1;
                     end
                  end
                  OPG_JP: pc_in = nnn;
                  OPG_CALL: begin
                     stack_we = 1'b1;
                     sp_in = (sp_ff == SP_W'(STACK_DEPTH - 1)) ? '0 : sp_ff + 1'b1;
                     pc_in = nnn;
                  end
                  OPG_SE_I: if (vx_ff == nn) pc_in = pc_adv + 12'd2;
                  OPG_SNE_I: if (vx_ff != nn) pc_in = pc_adv + 12'd2;
                  OPG_SE_R: begin
                     if (n != 4'h0) bad_in = 1'b1;
                     else if (vx_ff == vy_ff) pc_in = pc_adv + 12'd2;
                  end
                  OPG_SNE_R: begin
                     if (n != 4'h0) bad_in = 1'b1;
                     else if (vx_ff != vy_ff) pc_in = pc_adv + 12'd2;
                  end
                  OPG_LD_I: begin
                     rf_we = 1'b1;
                     rf_wd = nn;
                  end
                  OPG_ADD_I: begin
                     rf_we = 1'b1;
                     rf_wd = vx_ff + nn;
                  end
                  OPG_ALU: begin
                     rf_we = 1'b1;
                     case (n)
                        ALU_MOV: rf_wd = vy_ff;
                        ALU_OR:  rf_wd = vx_ff | vy_ff;
                        ALU_AND: rf_wd = vx_ff & vy_ff;
                        ALU_XOR: rf_wd = vx_ff ^ vy_ff;
                        ALU_ADD: begin
                           rf_wd = sum9[7:0];
                           vf_we = 1'b1;
                           vf_wd = {7'b0, sum9[8]};
                        end
                        ALU_SUB: begin
                           rf_wd = vx_ff - vy_ff;
                           vf_we = 1'b1;
                           vf_wd = {7'b0, vx_ff >= vy_ff};
                        end
                        ALU_SHR: begin
                           rf_wd = {1'b0, vx_ff[7:1]};
                           vf_we = 1'b1;
                           vf_wd = {7'b0, vx_ff[0]};
                        end
                        ALU_SUBN: begin
                           rf_wd = vy_ff - vx_ff;
                           vf_we = 1'b1;
                           vf_wd = {7'b0, vy_ff >= vx_ff};
                        end
                        ALU_SHL: begin
                           rf_wd = {vx_ff[6:0], 1'b0};
                           vf_we = 1'b1;
                           vf_wd = {7'b0, vx_ff[7]};
                        end
                        default: begin
                           rf_we = 1'b0;
                           bad_in = 1'b1;
                        end
                     endcase
                  end
                  OPG_SET_I: i_in = {4'h0, nnn};
                  OPG_JP_V0: pc_in = nnn + {4'h0, regs_ff[0]};
                  OPG_RND: begin
                     rf_we = 1'b1;
                     rf_wd = rnd_ff & nn;
                  end
                  OPG_DRAW: ;
                  OPG_KEY: if (nn != KEY_DOWN && nn != KEY_UP) bad_in = 1'b1;
                  default: begin
                     case (nn)
                        F_GET_DT: begin
                           rf_we = 1'b1;
                           rf_wd = dt_ff;
                        end
                        F_WAIT_KEY, F_BCD, F_STORE, F_LOAD: ;
                        F_SET_DT: dt_in = vx_ff;
                        F_SET_ST: st_in = vx_ff;
                        F_ADD_I: i_in = i_ff + {8'h00, vx_ff};
                        F_FONT: i_in = 16'(FONT_BASE) + {6'b0, vx_ff, 2'b0}
                                       + {8'h00, vx_ff};
                        default: bad_in = 1'b1;
                     endcase
                  end
               endcase
            end
         end
         ST_DRAW_RD: begin
            if (dp_stat.draw_done) begin
               vf_we = 1'b1;
               vf_wd = {7'b0, hit_ff};
            end
         end
         ST_LOAD_WR: begin
            rf_we = 1'b1;
            rf_wa = cnt_ff;
            rf_wd = mem_rd_ff;
         end
         default: ;
      endcase
   end

   always_comb begin
      mem_we = 1'b0;
      mem_wa = i_off;
      mem_wd = rd_data;
      mem_ra = i_off;
      case (step)
         ST_CLEAR: begin
            mem_we = 1'b1;
            mem_wa = sweep_ff;
            mem_wd = font_byte(sweep_ff);
         end
         ST_EXEC: begin
            mem_we = (cmd_ff == CMD_WRITE_MEM);
            mem_wa = addr_ff;
            mem_wd = wbyte_ff;
            mem_ra = addr_ff;
         end
         ST_STORE: mem_we = 1'b1;
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_wa] <= mem_wd;
      end
      mem_rd_ff <= mem[mem_ra];
   end

   assign fb_ra = (step == ST_DRAW_RD) ? draw_row : addr_ff[ROW_W-1:0];
   assign fb_cur = fb_rv_ff ? fb_rd_ff : 64'h0;
   assign sprite_dbl = {mem_rd_ff, 56'h0, mem_rd_ff, 56'h0} >> vx_ff[COL_W-1:0];
   assign sprite_mask = sprite_dbl[63:0];

   always_ff @(posedge clock) begin
      if (step == ST_DRAW_WR) begin
         fb_mem[row_ff] <= fb_cur ^ sprite_mask;
      end
      fb_rd_ff <= fb_mem[fb_ra];
      fb_rv_ff <= fb_vld_ff[fb_ra];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         fb_vld_ff <= '0;
      end else if (fb_clear) begin
         fb_vld_ff <= '0;
      end else if (step == ST_DRAW_WR) begin
         fb_vld_ff[row_ff] <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (stack_we) begin
         stack_mem[sp_ff] <= pc_adv;
      end
   end

   always_ff @(posedge clock) begin
      if (req_fire) begin
         cmd_ff   <= req_cmd;
         op_ff    <= req_opcode;
         addr_ff  <= req_address;
         wbyte_ff <= req_write_byte;
         rnd_ff   <= req_random_byte;
      end
      if (step == ST_RDX) vx_ff <= rd_data;
      if (step == ST_RDY) vy_ff <= rd_data;
      if (step == ST_DRAW_RD) row_ff <= draw_row;
      case (step)
         ST_EXEC:    data_ff <= 64'h0;
         ST_CAPTURE: begin
            if (cmd_ff == CMD_READ_MEM) begin
               data_ff <= {56'h0, mem_rd_ff};
            end else if (addr_ff < 12'(SCREEN_HEIGHT)) begin
               data_ff <= fb_cur;
            end else if (addr_ff >= REG_SEL_BASE && addr_ff < REG_SEL_END) begin
               data_ff <= {56'h0, vx_ff};
            end else begin
               data_ff <= 64'h0;
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < 16; k++) regs_ff[k] <= 8'h00;
         i_ff     <= 16'h0;
         pc_ff    <= 12'(PROGRAM_START);
         sp_ff    <= '0;
         dt_ff    <= 8'h00;
         st_ff    <= 8'h00;
         bad_ff   <= 1'b0;
         sweep_ff <= '0;
         cnt_ff   <= 4'h0;
         hit_ff   <= 1'b0;
      end else begin
         // flag write wins over a result write to VF
         if (rf_we && !(vf_we && rf_wa == 4'hF)) regs_ff[rf_wa] <= rf_wd;
         if (vf_we) regs_ff[15] <= vf_wd;
         i_ff   <= i_in;
         pc_ff  <= pc_in;
         sp_ff  <= sp_in;
         dt_ff  <= dt_in;
         st_ff  <= st_in;
         bad_ff <= bad_in;
         if (step == ST_CLEAR) sweep_ff <= sweep_ff + 1'b1;
         case (step)
            ST_EXEC: begin
               cnt_ff <= 4'h0;
               hit_ff <= 1'b0;
            end
            ST_DRAW_WR: begin
               cnt_ff <= cnt_ff + 4'h1;
               hit_ff <= hit_ff | (|(fb_cur & sprite_mask));
            end
            ST_STORE, ST_LOAD_WR: cnt_ff <= cnt_ff + 4'h1;
            default: ;
         endcase
      end
   end

   assign prog_counter = pc_ff;
   assign index_reg    = i_ff;
   assign flag_reg     = regs_ff[15];
   assign read_data    = data_ff;
   assign delay_value  = dt_ff;
   assign sound_value  = st_ff;
   assign bad_opcode   = bad_ff;

endmodule

// ===== hw/rtl/c8ex_ctrl.sv =====
// c8ex_ctrl: sequencer that steps the datapath through one item at a time
// and runs the memory clearing pass after reset. Depends on c8ex_pkg.
module c8ex_ctrl import c8ex_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output dp_cmd_type  dp_cmd,
   input  dp_stat_type dp_stat
);

   typedef enum logic [11:0] {
      S_IDLE    = 12'b000000000001,
      S_CLEAR   = 12'b000000000010,
      S_RDX     = 12'b000000000100,
      S_RDY     = 12'b000000001000,
      S_EXEC    = 12'b000000010000,
      S_CAPTURE = 12'b000000100000,
      S_DRAW_RD = 12'b000001000000,
      S_DRAW_WR = 12'b000010000000,
      S_STORE   = 12'b000100000000,
      S_LOAD_RD = 12'b001000000000,
      S_LOAD_WR = 12'b010000000000,
      S_RESP    = 12'b100000000000
   } state_type;

   state_type state_ff, state_in;

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = (state_ff == S_RESP);

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         S_IDLE:    if (req_valid) state_in = S_RDX;
         S_CLEAR:   if (dp_stat.clear_last) state_in = S_IDLE;
         S_RDX:     state_in = S_RDY;
         S_RDY:     state_in = S_EXEC;
         S_EXEC: begin
            case (dp_stat.kind)
               K_READ:  state_in = S_CAPTURE;
               K_DRAW:  state_in = S_DRAW_RD;
               K_STORE: state_in = S_STORE;
               K_LOAD:  state_in = S_LOAD_RD;
               default: state_in = S_RESP;
            endcase
         end
         S_CAPTURE: state_in = S_RESP;
         S_DRAW_RD: state_in = dp_stat.draw_done ? S_RESP : S_DRAW_WR;
         S_DRAW_WR: state_in = S_DRAW_RD;
         S_STORE:   if (dp_stat.move_last) state_in = S_RESP;
         S_LOAD_RD: state_in = S_LOAD_WR;
         S_LOAD_WR: state_in = dp_stat.move_last ? S_RESP : S_LOAD_RD;
         S_RESP:    if (rsp_ready) state_in = S_IDLE;
         default:   state_in = S_IDLE;
      endcase
   end

   always_comb begin
      case (state_ff)
         S_CLEAR:   dp_cmd.step = ST_CLEAR;
         S_RDX:     dp_cmd.step = ST_RDX;
         S_RDY:     dp_cmd.step = ST_RDY;
         S_EXEC:    dp_cmd.step = ST_EXEC;
         S_CAPTURE: dp_cmd.step = ST_CAPTURE;
         S_DRAW_RD: dp_cmd.step = ST_DRAW_RD;
         S_DRAW_WR: dp_cmd.step = ST_DRAW_WR;
         S_STORE:   dp_cmd.step = ST_STORE;
         S_LOAD_RD: dp_cmd.step = ST_LOAD_RD;
         S_LOAD_WR: dp_cmd.step = ST_LOAD_WR;
         default:   dp_cmd.step = ST_NONE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   a_accept_starts: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> state_ff == S_RDX)
      else $error("accepted item did not start");
   a_resp_returns: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready |=> req_ready && !rsp_valid)
      else $error("no return to idle after result");
   a_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("ready while result pending");
   a_reset_clears: assert property (@(posedge clock)
      reset |=> state_ff == S_CLEAR || reset)
      else $error("reset did not start clearing pass");

endmodule

// ===== hw/rtl/chip8_instruction_executor.sv =====
// chip8_instruction_executor: one item per command. After fetch and execute,
// reads add a capture step, DXYN a read and write step per sprite row, FX55
// a store step per register and FX65 a read and write step per register (one
// memory access per cycle). One item in flight; next accept after the result
// is taken. Synchronous reset, then a memory clearing pass (font load) over
// 4096 bytes before the first item is taken. Depends on c8ex_pkg, c8ex_ifs.
module chip8_instruction_executor import c8ex_pkg::*; (
   input logic        clock,
   input logic        reset,
   c8ex_req_if.sink   req_chan,
   c8ex_rsp_if.source rsp_chan
);

   dp_cmd_type  dp_cmd;
   dp_stat_type dp_stat;
   logic        req_ready, rsp_valid;

   assign req_chan.ready = req_ready;
   assign rsp_chan.valid = rsp_valid;

   c8ex_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_chan.valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_chan.ready),
      .dp_cmd    (dp_cmd),
      .dp_stat   (dp_stat)
   );

   c8ex_dpath u_dpath (
      .clock           (clock),
      .reset           (reset),
      .req_fire        (req_chan.valid && req_ready),
      .req_cmd         (cmd_type'(req_chan.cmd)),
      .req_opcode      (req_chan.opcode),
      .req_address     (req_chan.address),
      .req_write_byte  (req_chan.write_byte),
      .req_random_byte (req_chan.random_byte),
      .dp_cmd          (dp_cmd),
      .dp_stat         (dp_stat),
      .prog_counter    (rsp_chan.prog_counter),
      .index_reg       (rsp_chan.index_reg),
      .flag_reg        (rsp_chan.flag_reg),
      .read_data       (rsp_chan.read_data),
      .delay_value     (rsp_chan.delay_value),
      .sound_value     (rsp_chan.sound_value),
      .bad_opcode      (rsp_chan.bad_opcode)
   );

endmodule
